@@ design/grid_neighbor_majority_type_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the neighbour majority block
// Shared property forms, clocked on i_clk and disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef GRID_NEIGHBOR_MAJORITY_TYPE_DEFINES_SVH
`define GRID_NEIGHBOR_MAJORITY_TYPE_DEFINES_SVH

// Same-cycle implication
`define GNM_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define GNM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/gnm_pkg.sv @@
// ---------------------------------------------------------------------------
// gnm_pkg
// Types, constants and helpers shared by the neighbour majority block.
// ---------------------------------------------------------------------------
`default_nettype none

package gnm_pkg;

    // Field widths
    localparam int LABEL_W     = 3;
    localparam int COORD_W     = 6;
    localparam int CFG_W       = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int LIM_W       = 11;
    localparam int NCOORD_W    = 8;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 8;

    // Default grid geometry
    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;

    // Labels counted by a query, and the tally array size
    localparam int NUM_LABELS   = 8;
    localparam int LABEL_SPACE  = 1 << LABEL_W;
    localparam int TALLY_W      = 4;

    // Neighbour scan
    localparam int NBR_COUNT    = 8;
    localparam int STEP_W       = $clog2(NBR_COUNT);

    // Command queue
    localparam int QUEUE_DEPTH  = 2;

    // Opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

    // Reset values of the registers
    localparam logic [CFG_W-1:0] CFG_WIDTH_RST  = 7'd64;
    localparam logic [CFG_W-1:0] CFG_HEIGHT_RST = 7'd64;

    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
    } t_cfg;

    typedef struct packed {
        logic               is_query;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [LABEL_W-1:0] label;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_PICK
    } t_back_state;

    // Column offset of neighbour number idx
    function automatic logic [1:0] nbr_dc(input logic [STEP_W-1:0] idx);
        logic [1:0] d;
        case (idx)
            3'd0, 3'd3, 3'd5: d = 2'b11;
            3'd1, 3'd6:       d = 2'b00;
            3'd2, 3'd4, 3'd7: d = 2'b01;
            default:          d = 2'b00;
        endcase
        return d;
    endfunction

    // Row offset of neighbour number idx
    function automatic logic [1:0] nbr_dr(input logic [STEP_W-1:0] idx);
        logic [1:0] d;
        case (idx)
            3'd0, 3'd1, 3'd2: d = 2'b11;
            3'd3, 3'd4:       d = 2'b00;
            3'd5, 3'd6, 3'd7: d = 2'b01;
            default:          d = 2'b00;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

@@ design/gnm_queue.sv @@
// ---------------------------------------------------------------------------
// gnm_queue
// Short command queue between the front end and the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module gnm_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  gnm_pkg::t_cmd       i_cmd,
    input  wire logic           i_pop,
    output gnm_pkg::t_cmd       o_head,
    output gnm_pkg::t_q_stat    o_stat
);

    localparam int PTR_W = (gnm_pkg::QUEUE_DEPTH > 1) ? $clog2(gnm_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(gnm_pkg::QUEUE_DEPTH + 1);

    gnm_pkg::t_cmd          r_slot [gnm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]       r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]       r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]       r_count, n_count;
    logic                   do_push, do_pop;

    assign o_stat.full  = (r_count == CNT_W'(gnm_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_slot[r_rd_ptr];

    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(gnm_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(gnm_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the incoming command word
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

@@ design/gnm_front.sv @@
// ---------------------------------------------------------------------------
// gnm_front
// Accepts input words, holds the grid size registers and drops writes that
// fall outside the grid before they reach the command queue.
// ---------------------------------------------------------------------------
`default_nettype none

module gnm_front #(
    parameter int MAX_COLS = gnm_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = gnm_pkg::DEF_MAX_ROWS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Configuration writes
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [gnm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [gnm_pkg::CFG_W-1:0]        i_cfg_data,
    // Input words
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic                             i_opcode,
    input  wire logic [gnm_pkg::COORD_W-1:0]      i_col,
    input  wire logic [gnm_pkg::COORD_W-1:0]      i_row,
    input  wire logic [gnm_pkg::LABEL_W-1:0]      i_label,
    // Towards the queue
    input  gnm_pkg::t_q_stat                      i_q_stat,
    output logic                                  o_push,
    output gnm_pkg::t_cmd                         o_cmd,
    output gnm_pkg::t_cfg                         o_cfg
);

    localparam logic [gnm_pkg::LIM_W-1:0] COLS_LIM = gnm_pkg::LIM_W'(MAX_COLS);
    localparam logic [gnm_pkg::LIM_W-1:0] ROWS_LIM = gnm_pkg::LIM_W'(MAX_ROWS);

    gnm_pkg::t_cfg  r_cfg;
    logic           accept;
    logic           in_bounds;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Hold the grid size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= gnm_pkg::CFG_WIDTH_RST;
            r_cfg.height <= gnm_pkg::CFG_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                gnm_pkg::CFG_IDX_WIDTH:  r_cfg.width  <= i_cfg_data;
                gnm_pkg::CFG_IDX_HEIGHT: r_cfg.height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Classify the word: queries always go on, writes only inside the grid
    assign in_bounds = ({1'b0, i_col} < r_cfg.width)
                    && ({1'b0, i_row} < r_cfg.height)
                    && (gnm_pkg::LIM_W'(i_col) < COLS_LIM)
                    && (gnm_pkg::LIM_W'(i_row) < ROWS_LIM);

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && ((i_opcode == gnm_pkg::OP_QUERY) || in_bounds);

    assign o_cmd.is_query = (i_opcode == gnm_pkg::OP_QUERY);
    assign o_cmd.col      = i_col;
    assign o_cmd.row      = i_row;
    assign o_cmd.label    = i_label;

endmodule

`default_nettype wire

@@ design/gnm_back.sv @@
// ---------------------------------------------------------------------------
// gnm_back
// Holds the label grid, carries out writes and scans the eight neighbours
// of a queried cell one memory read a cycle, then picks the majority label.
// ---------------------------------------------------------------------------
`default_nettype none

module gnm_back #(
    parameter int MAX_COLS = gnm_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = gnm_pkg::DEF_MAX_ROWS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  gnm_pkg::t_cfg                     i_cfg,
    // From the queue
    input  gnm_pkg::t_cmd                     i_head,
    input  gnm_pkg::t_q_stat                  i_q_stat,
    output logic                              o_pop,
    // Result words
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [gnm_pkg::LABEL_W-1:0]       o_label
);

    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [gnm_pkg::LIM_W-1:0] COLS_LIM = gnm_pkg::LIM_W'(MAX_COLS);
    localparam logic [gnm_pkg::LIM_W-1:0] ROWS_LIM = gnm_pkg::LIM_W'(MAX_ROWS);

    logic [gnm_pkg::LABEL_W-1:0]  mem [DEPTH];

    gnm_pkg::t_back_state         r_state, n_state;
    logic [gnm_pkg::STEP_W-1:0]   r_step, n_step;
    logic [gnm_pkg::COORD_W-1:0]  r_col, n_col;
    logic [gnm_pkg::COORD_W-1:0]  r_row, n_row;
    logic                         r_rd_pend;
    logic [gnm_pkg::LABEL_W-1:0]  r_rd_data;
    logic [gnm_pkg::TALLY_W-1:0]  r_tally [gnm_pkg::LABEL_SPACE];
    logic                         r_out_valid;
    logic [gnm_pkg::LABEL_W-1:0]  r_out_label;

    logic                         mem_we, mem_re, tally_clr, out_load;
    logic [ADDR_W-1:0]            wr_addr, rd_addr;
    logic [1:0]                   dc, dr;
    logic [gnm_pkg::NCOORD_W-1:0] nc, nr;
    logic                         nbr_inb;
    logic [gnm_pkg::LABEL_W-1:0]  best_label;
    logic [gnm_pkg::TALLY_W-1:0]  best_cnt;

    // Neighbour coordinates for the current scan step
    assign dc = gnm_pkg::nbr_dc(r_step);
    assign dr = gnm_pkg::nbr_dr(r_step);
    assign nc = {2'b00, r_col} + {{(gnm_pkg::NCOORD_W-2){dc[1]}}, dc};
    assign nr = {2'b00, r_row} + {{(gnm_pkg::NCOORD_W-2){dr[1]}}, dr};

    assign nbr_inb = !nc[gnm_pkg::NCOORD_W-1] && !nr[gnm_pkg::NCOORD_W-1]
                  && (nc[gnm_pkg::CFG_W-1:0] < i_cfg.width)
                  && (nr[gnm_pkg::CFG_W-1:0] < i_cfg.height)
                  && (gnm_pkg::LIM_W'(nc[gnm_pkg::CFG_W-1:0]) < COLS_LIM)
                  && (gnm_pkg::LIM_W'(nr[gnm_pkg::CFG_W-1:0]) < ROWS_LIM);

    assign rd_addr = ADDR_W'(nr[gnm_pkg::CFG_W-1:0]) * ADDR_W'(MAX_COLS)
                   + ADDR_W'(nc[gnm_pkg::CFG_W-1:0]);
    assign wr_addr = ADDR_W'(i_head.row) * ADDR_W'(MAX_COLS) + ADDR_W'(i_head.col);

    // Sequencer: next state and control
    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_col     = r_col;
        n_row     = r_row;
        o_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        tally_clr = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            gnm_pkg::ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    if (i_head.is_query) begin
                        n_col     = i_head.col;
                        n_row     = i_head.row;
                        n_step    = '0;
                        tally_clr = 1'b1;
                        n_state   = gnm_pkg::ST_SCAN;
                    end else begin
                        mem_we = 1'b1;
                    end
                end
            end
            gnm_pkg::ST_SCAN: begin
                mem_re = nbr_inb;
                n_step = r_step + 1'b1;
                if (r_step == gnm_pkg::STEP_W'(gnm_pkg::NBR_COUNT - 1)) begin
                    n_state = gnm_pkg::ST_DRAIN;
                end
            end
            gnm_pkg::ST_DRAIN: begin
                n_state = gnm_pkg::ST_PICK;
            end
            gnm_pkg::ST_PICK: begin
                if (!r_out_valid || i_ready) begin
                    out_load = 1'b1;
                    n_state  = gnm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gnm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= gnm_pkg::ST_IDLE;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= mem_re;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step <= n_step;
        r_col  <= n_col;
        r_row  <= n_row;
    end

    // Label grid: one write or one read a cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= i_head.label;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Count each label as its read returns
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < gnm_pkg::LABEL_SPACE; k++) begin
            if (tally_clr) begin
                r_tally[k] <= '0;
            end else if (r_rd_pend && (r_rd_data == gnm_pkg::LABEL_W'(k))) begin
                r_tally[k] <= r_tally[k] + 1'b1;
            end
        end
    end

    // Pick the largest count, lowest label wins a tie
    always_comb begin
        best_label = '0;
        best_cnt   = '0;
        for (int k = 0; k < gnm_pkg::LABEL_SPACE; k++) begin
            if ((k < gnm_pkg::NUM_LABELS) && (r_tally[k] > best_cnt)) begin
                best_cnt   = r_tally[k];
                best_label = gnm_pkg::LABEL_W'(k);
            end
        end
    end

    // Output register: hold the word until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_label <= best_label;
        end
    end

    assign o_valid = r_out_valid;
    assign o_label = r_out_label;

endmodule

`default_nettype wire

@@ design/grid_neighbor_majority_type.sv @@
// Neighbour majority label grid.
// Input channel s_axis: tuser carries the opcode (write or query), tdata the
// column, row and label. A write stores the label at the cell when the cell
// lies inside the configured width and height, and gives no output word.
// A query gives one word on m_axis: the label seen most often among the up to
// eight in-bounds neighbours, lowest label on a tie, 0 with no neighbours.
// The configuration channel (index 0 width, index 1 height) is always ready
// and is to be written only while the block is idle; the block itself does
// not enforce this. The front end takes one word a cycle, while the queue is
// not full, into a two-entry command queue; the back end carries out a write
// as it pops it, and a query as a pop, eight neighbour scan steps (one
// single-port memory read per in-bounds neighbour), a drain step for the
// last count and a pick, taking no new command until the pick is done.
// A stalled receiver holds the result in the output register; the back
// end then waits in its pick step and the queue fills before s_axis_tready
// drops. Reset clears the registers to 64 x 64, the queue and the sequencer;
// the grid contents are not cleared and cells must be written before read.
// ---------------------------------------------------------------------------
// grid_neighbor_majority_type
// Top level: front end, command queue and back end of the label grid.
// ---------------------------------------------------------------------------
`default_nettype none

`include "grid_neighbor_majority_type_defines.svh"

module grid_neighbor_majority_type #(
    parameter int MAX_COLS = gnm_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = gnm_pkg::DEF_MAX_ROWS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [gnm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [gnm_pkg::CFG_W-1:0]         i_cfg_data,
    // Input words
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [5:0] col, [11:6] row, [14:12] label_in, [15] zero
    input  wire logic [gnm_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // [0] opcode
    input  wire logic                              s_axis_tuser,
    // Result words
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [2:0] top_label, [7:3] zero
    output logic [gnm_pkg::M_TDATA_W-1:0]          m_axis_tdata
);

    localparam int ROW_LO = gnm_pkg::COORD_W;
    localparam int LAB_LO = 2 * gnm_pkg::COORD_W;

    gnm_pkg::t_cfg                cfg;
    gnm_pkg::t_cmd                push_cmd, head_cmd;
    gnm_pkg::t_q_stat             q_stat;
    logic                         push, pop;
    logic [gnm_pkg::LABEL_W-1:0]  top_label;

    // Accept and classify input words
    gnm_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_opcode    (s_axis_tuser),
        .i_col       (s_axis_tdata[gnm_pkg::COORD_W-1:0]),
        .i_row       (s_axis_tdata[ROW_LO +: gnm_pkg::COORD_W]),
        .i_label     (s_axis_tdata[LAB_LO +: gnm_pkg::LABEL_W]),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_cmd       (push_cmd),
        .o_cfg       (cfg)
    );

    // Decouple front and back
    gnm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_stat  (q_stat)
    );

    // Carry out writes and queries
    gnm_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_head   (head_cmd),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_label  (top_label)
    );

    assign m_axis_tdata = gnm_pkg::M_TDATA_W'(top_label);

    // Checks on the queue hand-off
    `GNM_ASSERT_IMPLY(a_no_push_full, push, !q_stat.full, "push into a full queue")
    `GNM_ASSERT_IMPLY(a_no_pop_empty, pop, !q_stat.empty, "pop from an empty queue")
    `GNM_ASSERT_IMPLY(a_full_not_empty, q_stat.full, !q_stat.empty, "queue full and empty")

endmodule

`default_nettype wire
